// ===== hw/rtl/trd_pkg.sv =====
`timescale 1ns / 1ps
package trd_pkg;
  localparam int DefWidth  = 64;
  localparam int DefHeight = 64;
  localparam int CoordW = 16;
  localparam int ZW     = 24;
  localparam int DepthW = 26;
  localparam int ColorW = 24;
  localparam int CountW = 13;
  localparam int EdgeW  = 36;
  localparam int ProdW  = 61;
  localparam int SumW   = 63;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_DRAW   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [DepthW-1:0] DEPTH_FAR = 26'sd33554431;
  localparam logic [CountW-1:0] COUNT_MAX = 13'd8191;

  // one request as it crosses from the front to the back
  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [CoordW-1:0] x0, y0, x1, y1, x2, y2;
    logic [ZW-1:0]            z0, z1, z2;
    logic [ColorW-1:0]        color;
    logic [ZW-1:0]            bias;
    logic                     zero_area;
  } req_t;
endpackage

// ===== hw/rtl/trd_front.sv =====
`timescale 1ns / 1ps
// Accepts requests, flags degenerate triangles, and holds a two-entry queue.
module trd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  trd_pkg::req_t   in_req,
  output logic            q_valid,
  input  logic            q_ready,
  output trd_pkg::req_t   q_req
);
  trd_pkg::req_t q_mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push, pop;
  trd_pkg::req_t cls;
  logic signed [trd_pkg::EdgeW-1:0] area_a, area_b;

  // classify: zero area check at push
  always_comb begin
    area_a = 36'(signed'(34'(in_req.x1) - 34'(in_req.x0))) *
             36'(signed'(34'(in_req.y2) - 34'(in_req.y0)));
    area_b = 36'(signed'(34'(in_req.y1) - 34'(in_req.y0))) *
             36'(signed'(34'(in_req.x2) - 34'(in_req.x0)));
    cls = in_req;
    cls.zero_area = (area_a == area_b);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_req    = q_mem_r[rd_ptr_r];

  // store the entry
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cls;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_le2: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("push into full queue");
  a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule

// ===== hw/rtl/trd_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. Quotient fits in 24 bits
// because the dividend is below area * 2^24.
module trd_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [trd_pkg::SumW-1:0]  dividend,
  input  logic [trd_pkg::EdgeW-1:0] divisor,
  output logic                      busy,
  output logic [trd_pkg::ZW-1:0]    quotient
);
  localparam int RW = trd_pkg::EdgeW + 1;
  logic [trd_pkg::SumW-1:0]  num_r, num_nxt;
  logic [RW-1:0]             rem_r, rem_nxt;
  logic [trd_pkg::EdgeW-1:0] den_r;
  logic [5:0]                step_r;
  logic [RW-1:0]             trial;

  assign busy     = (step_r != 6'd0);
  assign quotient = num_r[trd_pkg::ZW-1:0];

  // shift one bit, subtract when it fits
  always_comb begin
    trial   = {rem_r[RW-2:0], num_r[trd_pkg::SumW-1]};
    num_nxt = {num_r[trd_pkg::SumW-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt    = trial - {1'b0, den_r};
      num_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 6'd0;
    end else if (start) begin
      step_r <= 6'(trd_pkg::SumW);
    end else if (busy) begin
      step_r <= step_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end
endmodule

// ===== hw/rtl/trd_back.sv =====
`timescale 1ns / 1ps
// Executes clear, draw and read against the pixel memories.
module trd_back #(
  parameter int WIDTH  = trd_pkg::DefWidth,
  parameter int HEIGHT = trd_pkg::DefHeight
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  trd_pkg::req_t            q_req,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [trd_pkg::ColorW-1:0] out_pixel_color,
  output logic signed [trd_pkg::DepthW-1:0] out_pixel_depth,
  output logic [trd_pkg::CountW-1:0] out_pixels_written
);
  localparam int NPIX = WIDTH * HEIGHT;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int XW   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int YW   = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam int PW   = 13; // pixel coordinate, signed
  localparam int EdgeW = trd_pkg::EdgeW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_PIX   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_TEST  = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_READ  = 4'd9;
  localparam logic [3:0] S_READ2 = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_INIT  = 4'd12;
  localparam logic [3:0] S_EDGE  = 4'd13;

  logic [3:0] state_r;
  trd_pkg::req_t req_r;

  // pixel memories
  logic signed [trd_pkg::DepthW-1:0] depth_mem [NPIX];
  logic [trd_pkg::ColorW-1:0]        color_mem [NPIX];
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr, mem_raddr;
  logic signed [trd_pkg::DepthW-1:0] mem_wdepth, rd_depth_r;
  logic [trd_pkg::ColorW-1:0]        mem_wcolor, rd_color_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_waddr] <= mem_wdepth;
      color_mem[mem_waddr] <= mem_wcolor;
    end
    rd_depth_r <= depth_mem[mem_raddr];
    rd_color_r <= color_mem[mem_raddr];
  end

  logic [AW-1:0] sweep_r;
  logic signed [PW-1:0] bx0_r, bx1_r, by0_r, by1_r, x_r, y_r;
  logic                 neg_r;
  logic [trd_pkg::EdgeW-1:0] area_r;
  logic signed [trd_pkg::EdgeW-1:0] e0_r, e1_r, e2_r;
  logic signed [trd_pkg::ProdW-1:0] p0_r, p1_r, p2_r;
  logic [trd_pkg::SumW-1:0] sum_r;
  logic [trd_pkg::CountW-1:0] count_r;
  logic [1:0] edge_i_r;
  logic [trd_pkg::ColorW-1:0] res_color_r;
  logic signed [trd_pkg::DepthW-1:0] res_depth_r;
  logic [trd_pkg::ColorW-1:0] clr_color_r;
  logic div_start, div_busy;
  logic [trd_pkg::ZW-1:0] div_q;

  trd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_r),
    .divisor(area_r), .busy(div_busy), .quotient(div_q)
  );

  // floor and ceil of 12.4 to pixel
  function automatic logic signed [PW-1:0] fl16(input logic signed [15:0] v);
    fl16 = PW'(v >>> 4);
  endfunction
  function automatic logic signed [PW-1:0] cl16(input logic signed [15:0] v);
    logic signed [16:0] t;
    t = 17'(v) + 17'sd15;
    cl16 = PW'(t >>> 4);
  endfunction
  function automatic logic signed [15:0] mn3(input logic signed [15:0] a, b, c);
    logic signed [15:0] m;
    m = (a < b) ? a : b;
    mn3 = (m < c) ? m : c;
  endfunction
  function automatic logic signed [15:0] mx3(input logic signed [15:0] a, b, c);
    logic signed [15:0] m;
    m = (a > b) ? a : b;
    mx3 = (m > c) ? m : c;
  endfunction

  // one edge function, shared in turn by each side of the triangle
  logic signed [15:0] ea_x, ea_y, eb_x, eb_y;
  logic signed [17:0] pcx, pcy;
  logic signed [trd_pkg::EdgeW-1:0] e_val;
  always_comb begin
    pcx = 18'(signed'({x_r, 4'b1000}));
    pcy = 18'(signed'({y_r, 4'b1000}));
    case (edge_i_r)
      2'd0: begin ea_x = req_r.x1; ea_y = req_r.y1; eb_x = req_r.x2; eb_y = req_r.y2; end
      2'd1: begin ea_x = req_r.x2; ea_y = req_r.y2; eb_x = req_r.x0; eb_y = req_r.y0; end
      default: begin ea_x = req_r.x0; ea_y = req_r.y0; eb_x = req_r.x1; eb_y = req_r.y1; end
    endcase
    e_val = EdgeW'(signed'(19'(eb_x) - 19'(ea_x))) * EdgeW'(signed'(19'(pcy) - 19'(ea_y)))
          - EdgeW'(signed'(19'(eb_y) - 19'(ea_y))) * EdgeW'(signed'(19'(pcx) - 19'(ea_x)));
    if (neg_r) e_val = -e_val;
  end

  logic signed [trd_pkg::EdgeW-1:0] area_s;
  always_comb begin
    area_s = EdgeW'(signed'(19'(req_r.x1) - 19'(req_r.x0))) *
             EdgeW'(signed'(19'(req_r.y2) - 19'(req_r.y0)))
           - EdgeW'(signed'(19'(req_r.y1) - 19'(req_r.y0))) *
             EdgeW'(signed'(19'(req_r.x2) - 19'(req_r.x0)));
  end

  logic signed [PW-1:0] rx, ry;
  logic in_buf;
  assign rx = fl16(req_r.x0);
  assign ry = fl16(req_r.y0);
  assign in_buf = (rx >= 0) && (rx < PW'(WIDTH)) && (ry >= 0) && (ry < PW'(HEIGHT));

  logic [AW-1:0] pix_addr;
  assign pix_addr = AW'(y_r[YW-1:0] * WIDTH) + AW'(x_r[XW-1:0]);

  logic signed [trd_pkg::DepthW-1:0] frag;
  assign frag = trd_pkg::DepthW'(div_q) - trd_pkg::DepthW'(req_r.bias);

  // box that misses the buffer entirely, judged before it is clamped
  logic box_off;
  assign box_off = (bx1_r < 0) || (by1_r < 0) ||
                   (bx0_r > PW'(WIDTH - 1)) || (by0_r > PW'(HEIGHT - 1));

  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign div_start = (state_r == S_SUM);

  // memory port control
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = pix_addr;
    mem_wdepth = frag;
    mem_wcolor = req_r.color;
    mem_raddr  = pix_addr;
    if (state_r == S_CLEAR || state_r == S_INIT) begin
      mem_we     = 1'b1;
      mem_waddr  = sweep_r;
      mem_wdepth = trd_pkg::DEPTH_FAR;
      mem_wcolor = (state_r == S_INIT) ? '0 : clr_color_r;
    end else if (state_r == S_TEST) begin
      mem_we = (frag < rd_depth_r);
    end else if (state_r == S_READ) begin
      mem_raddr = AW'(ry[YW-1:0] * WIDTH) + AW'(rx[XW-1:0]);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      sweep_r <= '0;
    end else begin
      case (state_r)
        S_INIT, S_CLEAR: begin
          sweep_r <= sweep_r + AW'(1);
          if (sweep_r == AW'(NPIX - 1)) begin
            sweep_r <= '0;
            state_r <= (state_r == S_INIT) ? S_IDLE : S_OUT;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            if (q_req.cmd == trd_pkg::CMD_CLEAR) state_r <= S_CLEAR;
            else if (q_req.cmd == trd_pkg::CMD_DRAW && !q_req.zero_area) state_r <= S_SETUP;
            else if (q_req.cmd == trd_pkg::CMD_READ) state_r <= S_READ;
            else state_r <= S_OUT;
          end
        end
        S_SETUP: state_r <= box_off ? S_OUT : S_EDGE;
        S_EDGE: state_r <= (edge_i_r == 2'd2) ? S_PIX : S_EDGE;
        S_PIX: state_r <= (e0_r < 0 || e1_r < 0 || e2_r < 0) ? S_NEXT : S_MUL;
        S_MUL: state_r <= S_SUM;
        S_SUM: state_r <= S_DIV;
        S_DIV: if (!div_busy) state_r <= S_TEST;
        S_TEST: state_r <= S_NEXT;
        S_NEXT: begin
          if (x_r == bx1_r && y_r == by1_r) state_r <= S_OUT;
          else state_r <= S_EDGE;
        end
        S_READ: state_r <= S_READ2;
        S_READ2: state_r <= S_OUT;
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        req_r       <= q_req;
        clr_color_r <= q_req.color;
        count_r     <= '0;
        res_color_r <= '0;
        res_depth_r <= '0;
        edge_i_r    <= 2'd0;
        bx0_r <= fl16(mn3(q_req.x0, q_req.x1, q_req.x2));
        bx1_r <= cl16(mx3(q_req.x0, q_req.x1, q_req.x2));
        by0_r <= fl16(mn3(q_req.y0, q_req.y1, q_req.y2));
        by1_r <= cl16(mx3(q_req.y0, q_req.y1, q_req.y2));
      end
      S_SETUP: begin
        neg_r  <= area_s < 0;
        area_r <= (area_s < 0) ? EdgeW'(-area_s) : EdgeW'(area_s);
        if (bx0_r < 0) begin bx0_r <= '0; x_r <= '0; end else x_r <= bx0_r;
        if (by0_r < 0) begin by0_r <= '0; y_r <= '0; end else y_r <= by0_r;
        if (bx1_r > PW'(WIDTH - 1)) bx1_r <= PW'(WIDTH - 1);
        if (by1_r > PW'(HEIGHT - 1)) by1_r <= PW'(HEIGHT - 1);
      end
      S_EDGE: begin
        case (edge_i_r)
          2'd0: e0_r <= e_val;
          2'd1: e1_r <= e_val;
          default: e2_r <= e_val;
        endcase
        edge_i_r <= (edge_i_r == 2'd2) ? 2'd0 : edge_i_r + 2'd1;
      end
      S_MUL: begin
        p0_r <= trd_pkg::ProdW'(e0_r) * trd_pkg::ProdW'(signed'({1'b0, req_r.z0}));
        p1_r <= trd_pkg::ProdW'(e1_r) * trd_pkg::ProdW'(signed'({1'b0, req_r.z1}));
        p2_r <= trd_pkg::ProdW'(e2_r) * trd_pkg::ProdW'(signed'({1'b0, req_r.z2}));
      end
      S_SUM: ;
      S_TEST: begin
        if (frag < rd_depth_r && count_r != trd_pkg::COUNT_MAX) count_r <= count_r + 13'd1;
      end
      S_NEXT: begin
        if (x_r == bx1_r) begin
          x_r <= bx0_r;
          y_r <= y_r + PW'(1);
        end else begin
          x_r <= x_r + PW'(1);
        end
      end
      S_READ2: begin
        if (in_buf) begin
          res_color_r <= rd_color_r;
          res_depth_r <= rd_depth_r;
        end
      end
      default: ;
    endcase
  end

  assign sum_r = trd_pkg::SumW'(p0_r) + trd_pkg::SumW'(p1_r) + trd_pkg::SumW'(p2_r);
  assign out_pixel_color    = res_color_r;
  assign out_pixel_depth    = res_depth_r;
  assign out_pixels_written = count_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_div_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TEST |-> !div_busy) else $error("depth used before divide done");
  a_idle_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> !out_valid) else $error("accept while result pending");
endmodule

// ===== hw/rtl/triangle_raster_depth_test.sv =====
`timescale 1ns / 1ps
// Channel  | handshake              | payload
// in_      | in_valid / in_ready    | command, three vertices, fill_color, depth_bias
// out_     | out_valid / out_ready  | pixel_color, pixel_depth, pixels_written
// After reset, a pass over every pixel sets the buffers before any request runs.
// Clear sweeps every pixel; read fetches one pixel.
// Draw visits every pixel of the clamped bounding box (none for a zero-area
// triangle or a box off the buffer), waiting on the 63-step divider per covered one.
// A two-entry request queue lets the input side keep taking requests while
// the back end works or the result waits.
module triangle_raster_depth_test #(
  parameter int WIDTH  = trd_pkg::DefWidth,
  parameter int HEIGHT = trd_pkg::DefHeight
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_command,
  input  logic signed [15:0] in_v0_x, in_v0_y,
  input  logic [23:0] in_v0_depth,
  input  logic signed [15:0] in_v1_x, in_v1_y,
  input  logic [23:0] in_v1_depth,
  input  logic signed [15:0] in_v2_x, in_v2_y,
  input  logic [23:0] in_v2_depth,
  input  logic [23:0] in_fill_color,
  input  logic [23:0] in_depth_bias,
  output logic out_valid,
  input  logic out_ready,
  output logic [23:0] out_pixel_color,
  output logic signed [25:0] out_pixel_depth,
  output logic [12:0] out_pixels_written
);
  trd_pkg::req_t in_req, q_req;
  logic q_valid, q_ready;

  always_comb begin
    in_req.cmd = in_command;
    in_req.x0 = in_v0_x; in_req.y0 = in_v0_y; in_req.z0 = in_v0_depth;
    in_req.x1 = in_v1_x; in_req.y1 = in_v1_y; in_req.z1 = in_v1_depth;
    in_req.x2 = in_v2_x; in_req.y2 = in_v2_y; in_req.z2 = in_v2_depth;
    in_req.color = in_fill_color;
    in_req.bias = in_depth_bias;
    in_req.zero_area = 1'b0;
  end

  trd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  trd_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_color(out_pixel_color), .out_pixel_depth(out_pixel_depth),
    .out_pixels_written(out_pixels_written)
  );
endmodule
